### design/utccet_pkg.sv
// shared types, constants and calendar tables for the utc to central european time block
package utccet_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] MARCH    = 4'd3;
  localparam logic [MONTH_W-1:0] OCTOBER  = 4'd10;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  // both months that hold a summer time switch have 31 days
  localparam logic [DAY_W-1:0] SWITCH_MONTH_LEN = 5'd31;
  localparam logic [HOUR_W-1:0] SWITCH_HOUR = 5'd1;
  localparam logic [5:0] HOURS_PER_DAY = 6'd24;

  // floor(z / 25) = (z * RECIP_25) >> RECIP_SHIFT for z below 4096
  localparam logic [10:0] RECIP_25 = 11'd1311;
  localparam int RECIP_SHIFT = 15;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } time_fields_t;

  // month length of a common year, 31 for codes that are no month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // month offset of the weekday formula, month 1 is january
  function automatic logic [2:0] sak_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] off;
    unique case (m)
      4'd1, 4'd5, 4'd13:  off = 3'd0;
      4'd2, 4'd6, 4'd14:  off = 3'd3;
      4'd3, 4'd11, 4'd15: off = 3'd2;
      4'd4:               off = 3'd5;
      4'd7:               off = 3'd5;
      4'd8:               off = 3'd1;
      4'd9:               off = 3'd4;
      4'd10:              off = 3'd6;
      4'd12:              off = 3'd4;
      default:            off = 3'd4;
    endcase
    return off;
  endfunction

endpackage

### design/utc_to_central_european_time.sv
// utc to central european time converter: four stage pipeline with eu summer time rule
// throughput: one transaction per cycle; the stages are weekday divide multiply,
//   weekday sum, summer time decision and the date rollover in the output register
// each stage holds its item under backpressure and frees as soon as the next one moves
// reset (rst, synchronous) clears all stage valid bits; payload registers are not reset
module utc_to_central_european_time (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] utc_year,
  input  logic [3:0]  utc_month,
  input  logic [4:0]  utc_day,
  input  logic [4:0]  utc_hour,
  input  logic [5:0]  utc_minute,
  input  logic [5:0]  utc_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] local_year,
  output logic [3:0]  local_month,
  output logic [4:0]  local_day,
  output logic [4:0]  local_hour,
  output logic [5:0]  local_minute,
  output logic [5:0]  local_second,
  output logic        summer_time
);
  import utccet_pkg::*;

  time_fields_t in_f;
  assign in_f = '{year: utc_year, month: utc_month, day: utc_day, hour: utc_hour,
                  minute: utc_minute, second: utc_second};

  // stage valid bits and ready chain
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: year / 100 via year / 4 times reciprocal of 25
  time_fields_t f1;
  logic [22:0]  prod1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      f1    <= in_f;
      prod1 <= 23'(in_f.year[13:2]) * 23'(RECIP_25);
    end
  end

  // stage 2: leap year and weekday sum of the switch month's last day
  logic [11:0] z2;
  logic [7:0]  c2;
  logic        leap_c;
  logic [5:0]  k2;
  logic [14:0] sum_c;
  time_fields_t f2;
  logic [14:0]  sum2;
  logic         leap2;

  always_comb begin
    z2     = f1.year[13:2];
    c2     = prod1[22:RECIP_SHIFT];
    leap_c = (f1.year[1:0] == 2'b00) &&
             ((13'(z2) != 13'(c2) * 13'd25) || (c2[1:0] == 2'b00));
    k2     = 6'(sak_offset(f1.month)) + 6'(SWITCH_MONTH_LEN);
    sum_c  = 15'(f1.year) + 15'(z2) - 15'(c2) + 15'(c2[7:2]) + 15'(k2);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      f2    <= f1;
      sum2  <= sum_c;
      leap2 <= leap_c;
    end
  end

  // stage 3: weekday by octal digit folding, last sunday, summer decision, month length
  logic [5:0] fold_a;
  logic [3:0] fold_b;
  logic [3:0] fold_c;
  logic [2:0] wd;
  logic [4:0] last_sun;
  logic       st_c;
  logic [4:0] dim_c;
  time_fields_t f3;
  logic         st3;
  logic [4:0]   dim3;

  always_comb begin
    // 8 is 1 mod 7, so digit sums keep the remainder
    fold_a = 6'(sum2[14:12]) + 6'(sum2[11:9]) + 6'(sum2[8:6]) + 6'(sum2[5:3])
           + 6'(sum2[2:0]);
    fold_b = 4'(fold_a[5:3]) + 4'(fold_a[2:0]);
    fold_c = 4'(fold_b[3]) + 4'(fold_b[2:0]);
    wd     = (fold_c >= 4'd7) ? 3'(fold_c - 4'd7) : fold_c[2:0];
    last_sun = SWITCH_MONTH_LEN - 5'(wd);

    if (f2.month < MARCH || f2.month > OCTOBER) begin
      st_c = 1'b0;
    end else if (f2.month > MARCH && f2.month < OCTOBER) begin
      st_c = 1'b1;
    end else if (f2.month == MARCH) begin
      st_c = (f2.day > last_sun) || ((f2.day == last_sun) && (f2.hour >= SWITCH_HOUR));
    end else begin
      st_c = (f2.day < last_sun) || ((f2.day == last_sun) && (f2.hour < SWITCH_HOUR));
    end

    if (f2.month == FEBRUARY) begin
      dim_c = month_len(f2.month) + 5'(leap2);
    end else begin
      dim_c = month_len(f2.month);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      f3   <= f2;
      st3  <= st_c;
      dim3 <= dim_c;
    end
  end

  // stage 4: add offset and roll the date forward into the output register
  logic [5:0] hour_sum;
  logic [5:0] day_inc;
  logic [4:0] month_inc;
  time_fields_t f4_next;

  always_comb begin
    hour_sum  = 6'(f3.hour) + (st3 ? 6'd2 : 6'd1);
    day_inc   = 6'(f3.day) + 6'd1;
    month_inc = 5'(f3.month) + 5'd1;
    f4_next   = f3;
    f4_next.hour = hour_sum[4:0];
    if (hour_sum >= HOURS_PER_DAY) begin
      f4_next.hour = 5'(hour_sum - HOURS_PER_DAY);
      f4_next.day  = day_inc[4:0];
      if (day_inc > 6'(dim3)) begin
        f4_next.day   = 5'd1;
        f4_next.month = month_inc[3:0];
        if (month_inc > 5'(DECEMBER)) begin
          f4_next.month = 4'd1;
          f4_next.year  = f3.year + 14'd1;
        end
      end
    end
  end

  time_fields_t f4;
  logic         st4;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      f4  <= f4_next;
      st4 <= st3;
    end
  end

  assign out_valid    = v4;
  assign local_year   = f4.year;
  assign local_month  = f4.month;
  assign local_day    = f4.day;
  assign local_hour   = f4.hour;
  assign local_minute = f4.minute;
  assign local_second = f4.second;
  assign summer_time  = st4;

endmodule

### tb/cet_conversion_checker.sv
// watches both channels of the utc to cet converter, predicts each result and compares it
`timescale 1ns / 1ps

module cet_conversion_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [utccet_pkg::YEAR_W-1:0]   utc_year,
  input  logic [utccet_pkg::MONTH_W-1:0]  utc_month,
  input  logic [utccet_pkg::DAY_W-1:0]    utc_day,
  input  logic [utccet_pkg::HOUR_W-1:0]   utc_hour,
  input  logic [utccet_pkg::MINUTE_W-1:0] utc_minute,
  input  logic [utccet_pkg::SECOND_W-1:0] utc_second,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [utccet_pkg::YEAR_W-1:0]   local_year,
  input  logic [utccet_pkg::MONTH_W-1:0]  local_month,
  input  logic [utccet_pkg::DAY_W-1:0]    local_day,
  input  logic [utccet_pkg::HOUR_W-1:0]   local_hour,
  input  logic [utccet_pkg::MINUTE_W-1:0] local_minute,
  input  logic [utccet_pkg::SECOND_W-1:0] local_second,
  input  logic                            summer_time,
  output int                              fail_count,
  output int                              pending,
  output int                              results_seen,
  output int                              summer_seen,
  output int                              rollover_seen
);
  import utccet_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    time_fields_t stamp;
    logic         summer;
    logic         next_day;
  } local_time_t;

  local_time_t expected_local[$];

  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // codes that are no month count as 31 days long
  function automatic int unsigned days_of(input int unsigned yr, input int unsigned mo);
    int unsigned len;
    case (mo)
      2:             len = is_leap(yr) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  // weekday of a date in march..december, 0 is sunday
  function automatic int unsigned weekday_of(input int unsigned yr, input int unsigned mo,
                                             input int unsigned dy);
    int unsigned shift;
    case (mo)
      4, 7:     shift = 5;
      3, 11:    shift = 2;
      5:        shift = 0;
      6:        shift = 3;
      8:        shift = 1;
      9, 12:    shift = 4;
      default:  shift = 6;
    endcase
    return (yr + yr / 4 - yr / 100 + yr / 400 + shift + dy) % 7;
  endfunction

  function automatic bit summer_rule(input int unsigned yr, input int unsigned mo,
                                     input int unsigned dy, input int unsigned hr);
    int unsigned switch_day;
    bit          result;
    if (mo < 3 || mo > 10) begin
      result = 1'b0;
    end else if (mo > 3 && mo < 10) begin
      result = 1'b1;
    end else begin
      switch_day = days_of(yr, mo) - weekday_of(yr, mo, days_of(yr, mo));
      if (mo == 3) begin
        result = (dy > switch_day) || (dy == switch_day && hr >= 1);
      end else begin
        result = (dy < switch_day) || (dy == switch_day && hr < 1);
      end
    end
    return result;
  endfunction

  function automatic local_time_t utc_to_local(input logic [YEAR_W-1:0] y,
                                               input logic [MONTH_W-1:0] m,
                                               input logic [DAY_W-1:0] d,
                                               input logic [HOUR_W-1:0] h,
                                               input logic [MINUTE_W-1:0] mi,
                                               input logic [SECOND_W-1:0] s);
    int unsigned yr, mo, dy, hr;
    local_time_t r;
    yr = y;
    mo = m;
    dy = d;
    hr = h;
    r.summer = summer_rule(yr, mo, dy, hr);
    hr = hr + (r.summer ? 2 : 1);
    r.next_day = (hr >= 24);
    if (hr >= 24) begin
      hr = hr - 24;
      dy = dy + 1;
      if (dy > days_of(yr, mo)) begin
        dy = 1;
        mo = mo + 1;
        if (mo > 12) begin
          mo = 1;
          yr = yr + 1;
        end
      end
    end
    r.stamp.year   = YEAR_W'(yr);
    r.stamp.month  = MONTH_W'(mo);
    r.stamp.day    = DAY_W'(dy);
    r.stamp.hour   = HOUR_W'(hr);
    r.stamp.minute = mi;
    r.stamp.second = s;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [YEAR_W-1:0] want_v,
                                 input logic [YEAR_W-1:0] got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
    end
  endtask

  task automatic check_field(input string what, input logic [YEAR_W-1:0] want_v,
                             input logic [YEAR_W-1:0] got_v);
    if (got_v !== want_v) begin
      report_mismatch(what, want_v, got_v);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
    summer_seen = 0;
    rollover_seen = 0;
  end

  always @(posedge clk) begin : monitor
    local_time_t want;
    if (rst) begin
      expected_local.delete();
    end else begin
      // push before pop so a same-edge result still finds its expectation
      if (in_valid && in_ready) begin
        expected_local.push_back(utc_to_local(utc_year, utc_month, utc_day, utc_hour,
                                              utc_minute, utc_second));
      end
      if (out_valid && out_ready) begin
        if (expected_local.size() == 0) begin
          report_mismatch("result transaction with nothing pending, local_hour",
                          '0, local_hour);
        end else begin
          want = expected_local.pop_front();
          check_field("local_year", want.stamp.year, local_year);
          check_field("local_month", want.stamp.month, local_month);
          check_field("local_day", want.stamp.day, local_day);
          check_field("local_hour", want.stamp.hour, local_hour);
          check_field("local_minute", want.stamp.minute, local_minute);
          check_field("local_second", want.stamp.second, local_second);
          check_field("summer_time", want.summer, summer_time);
          results_seen++;
          if (want.summer) summer_seen++;
          if (want.next_day) rollover_seen++;
        end
      end
    end
    pending = expected_local.size();
  end

endmodule

### tb/tb_top.sv
// stimulus, clock, reset and verdict for the utc to central european time converter
`timescale 1ns / 1ps

module tb_top;
  import utccet_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int IDLE_PCT     = 21;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [YEAR_W-1:0]   utc_year;
  logic [MONTH_W-1:0]  utc_month;
  logic [DAY_W-1:0]    utc_day;
  logic [HOUR_W-1:0]   utc_hour;
  logic [MINUTE_W-1:0] utc_minute;
  logic [SECOND_W-1:0] utc_second;
  logic                out_valid;
  logic                out_ready;
  logic [YEAR_W-1:0]   local_year;
  logic [MONTH_W-1:0]  local_month;
  logic [DAY_W-1:0]    local_day;
  logic [HOUR_W-1:0]   local_hour;
  logic [MINUTE_W-1:0] local_minute;
  logic [SECOND_W-1:0] local_second;
  logic                summer_time;

  int  fail_count;
  int  pending;
  int  results_seen;
  int  summer_seen;
  int  rollover_seen;
  int  hold_requests;
  int  switch_items;
  bit  quiet;

  utc_to_central_european_time DUT (.*);

  cet_conversion_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random backpressure, plus long hold-offs on request from the sender
  initial begin : receiver
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && holds_done < hold_requests) begin
        holds_done++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic push_time(input int y, input int m, input int d, input int h,
                           input int mi, input int s);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    utc_year   <= YEAR_W'(y);
    utc_month  <= MONTH_W'(m);
    utc_day    <= DAY_W'(d);
    utc_hour   <= HOUR_W'(h);
    utc_minute <= MINUTE_W'(mi);
    utc_second <= SECOND_W'(s);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int y, m, d, h, mi, s, kind;
    rst = 1'b1;
    in_valid = 1'b0;
    utc_year = '0;
    utc_month = '0;
    utc_day = '0;
    utc_hour = '0;
    utc_minute = '0;
    utc_second = '0;
    quiet = 1'b0;
    hold_requests = 0;
    switch_items = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // spring switch: last sunday of march 2024 is the 31st
    push_time(2024, 3, 31, 0, 59, 59);
    push_time(2024, 3, 31, 1, 0, 0);
    push_time(2024, 3, 30, 23, 30, 15);
    // autumn switch: last sunday of october 2024 is the 27th
    push_time(2024, 10, 27, 0, 30, 0);
    push_time(2024, 10, 27, 1, 0, 0);
    push_time(2024, 10, 26, 22, 10, 5);
    // leap years and month ends
    push_time(2024, 2, 28, 23, 1, 2);
    push_time(2024, 2, 29, 23, 1, 2);
    push_time(1900, 2, 28, 23, 0, 0);
    push_time(2000, 2, 29, 23, 0, 0);
    push_time(2023, 10, 31, 23, 45, 0);
    // year extremes, year 0 is leap, top year wraps to 0
    push_time(9998, 12, 31, 23, 59, 60);
    push_time(1, 1, 1, 0, 0, 0);
    push_time(0, 2, 29, 23, 0, 0);
    push_time(16383, 12, 31, 23, 0, 0);
    // month codes that are no month
    push_time(2021, 0, 31, 23, 0, 0);
    push_time(2021, 13, 31, 23, 0, 0);
    push_time(2021, 15, 5, 10, 0, 0);
    // days beyond the month and day 0
    push_time(2022, 6, 0, 23, 0, 0);
    push_time(2023, 4, 31, 22, 0, 0);
    push_time(2023, 2, 31, 5, 0, 0);
    // hours beyond the day
    push_time(2023, 7, 15, 31, 0, 0);
    push_time(2023, 1, 10, 24, 0, 0);
    // all ones and all zeros
    push_time(16383, 15, 31, 31, 63, 63);
    push_time(0, 0, 0, 0, 0, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300 || n == 950) hold_requests++;
      if (n == 450 || n == 850) begin
        // sender pause until the pipeline has drained
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      quiet = (n >= 550 && n < 750);
      kind = $urandom_range(99);
      mi = $urandom_range(59);
      s = $urandom_range(60);
      if (kind < 55) begin
        // ordinary dates, weighted toward day ends and month ends
        y = ($urandom_range(3) == 0) ? $urandom_range(1890, 2110) : $urandom_range(1, 9998);
        m = $urandom_range(1, 12);
        d = ($urandom_range(1) == 0) ? $urandom_range(1, 28) : $urandom_range(27, 31);
        h = ($urandom_range(2) == 0) ? $urandom_range(22, 23) : $urandom_range(23);
      end else if (kind < 85) begin
        // the week that holds a summer time switch
        y = $urandom_range(1, 9998);
        m = ($urandom_range(1) == 0) ? 3 : 10;
        d = $urandom_range(24, 31);
        case ($urandom_range(3))
          0:       h = 0;
          1:       h = 1;
          2:       h = $urandom_range(22, 23);
          default: h = $urandom_range(23);
        endcase
        switch_items++;
      end else begin
        // raw noise over the full field widths
        y = $urandom_range(16383);
        m = $urandom_range(15);
        d = $urandom_range(31);
        h = $urandom_range(31);
        mi = $urandom_range(63);
        s = $urandom_range(63);
      end
      push_time(y, m, d, h, mi, s);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("converted %0d timestamps: %0d in summer time, %0d rolled into the next day",
             results_seen, summer_seen, rollover_seen);
    $display("random part put %0d timestamps in the switch weeks of march and october",
             switch_items);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
